// ----- design/palette_delta_decoder_defines.svh -----
// assertion macros for the palette delta decoder
`ifndef PALETTE_DELTA_DECODER_DEFINES_SVH
`define PALETTE_DELTA_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define PDD_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("palette delta decoder: implication check failed");
// next-cycle implication
`define PDD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("palette delta decoder: next-cycle check failed");
`else
`define PDD_ASSERT_IMPLIES(label, ante, cons)
`define PDD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/pdd_pkg.sv -----
package pdd_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int ENTRY_W = $clog2(PALETTE_ENTRIES);
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	// error codes reported with each chunk byte
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_CUT = 2'd2;

	// chunk parser phases
	typedef enum logic [2:0] {
		PH_LENGTH,
		PH_CMD,
		PH_START,
		PH_GREEN,
		PH_BLUE,
		PH_SKIP_COMMIT,
		PH_SKIP_ONLY
	} phase_t;

	// work handed from the parser to the palette engine
	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_READ,
		JOB_WRITE,
		JOB_COPY
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic [ENTRY_W:0] addr_a;   // read address or copy source, bank bit on top
		logic [ENTRY_W:0] addr_b;   // write address or copy destination
		logic [7:0] count;          // copy length, 1 to 128
		logic zero;                 // copy writes zero entries
		logic [23:0] data;          // raw entry {r, g, b}
		logic done;
		logic [1:0] err;
	} job_t;

	// palette engine states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_COPY,
		BK_DRAIN
	} back_state_t;

	// 6-bit color value to 8 bits
	function automatic logic [7:0] expand6(input logic [7:0] v);
		return {v[5:0], v[5:4]};
	endfunction

endpackage

// ----- design/pdd_front.sv -----
module pdd_front (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [15:0] s_tdata,     // chunk_byte, entry_index
	input logic [0:0] s_tuser,      // op
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_data,     // palette_enable
	input logic q_full,
	output logic q_push,
	output pdd_pkg::job_t q_job
);
	import pdd_pkg::*;

	logic en_q;
	phase_t phase_q, phase_n, phase_t_v;
	logic [9:0] rem_q, rem_n, rem_dec;
	logic [ENTRY_W:0] new_q, new_n;
	logic [ENTRY_W:0] old_q, old_n;
	logic [6:0] pend_q, pend_n;
	logic [15:0] color_q, color_n;
	logic bank_q, bank_n;
	logic oldv_q, oldv_n;

	logic accept;
	logic [7:0] byte_v;
	logic [7:0] idx_v;
	logic is_len;
	logic do_copy;
	logic [7:0] c_count;
	logic [ENTRY_W:0] c_start;
	logic [9:0] c_old_sum;
	logic [9:0] c_new_sum;
	logic c_ovf;

	assign s_tready = !q_full;
	assign cfg_ready = 1'b1;
	assign accept = s_tvalid && s_tready;
	assign q_push = accept;
	assign byte_v = s_tdata[7:0];
	assign idx_v = s_tdata[15:8];
	assign is_len = (phase_q == PH_LENGTH) || (rem_q == 10'd0);

	// copy operands: running old index, or start byte after a 0x40 command
	always_comb begin
		if (phase_q == PH_START) begin
			c_count = {1'b0, pend_q};
			c_start = {1'b0, byte_v};
		end else begin
			c_count = {1'b0, byte_v[6:0]} + 8'd1;
			c_start = old_q;
		end
		c_old_sum = {1'b0, c_start} + {2'b00, c_count};
		c_new_sum = {1'b0, new_q} + {2'b00, c_count};
		c_ovf = (c_old_sum > 10'(PALETTE_ENTRIES)) || (c_new_sum > 10'(PALETTE_ENTRIES));
	end

	// byte parsing and job build
	always_comb begin
		phase_n = phase_q;
		phase_t_v = phase_q;
		rem_n = rem_q;
		rem_dec = rem_q - 10'd1;
		new_n = new_q;
		old_n = old_q;
		pend_n = pend_q;
		color_n = color_q;
		bank_n = bank_q;
		oldv_n = oldv_q;
		do_copy = 1'b0;
		q_job = '0;
		q_job.kind = JOB_NONE;
		q_job.err = ERR_NONE;
		if (s_tuser[0]) begin
			q_job.kind = JOB_READ;
			q_job.addr_a = {bank_q, idx_v};
		end else if (is_len) begin
			if (byte_v == 8'd0) begin
				q_job.done = 1'b1;
				phase_n = PH_LENGTH;
			end else begin
				rem_n = {byte_v, 2'b00} - 10'd1;
				new_n = '0;
				old_n = '0;
				phase_n = en_q ? PH_CMD : PH_SKIP_ONLY;
			end
		end else begin
			case (phase_q)
				PH_CMD: begin
					if (byte_v[7]) begin
						do_copy = 1'b1;
					end else if (byte_v[6]) begin
						pend_n = {1'b0, byte_v[5:0]} + 7'd1;
						phase_t_v = PH_START;
					end else begin
						color_n[7:0] = expand6(byte_v);
						phase_t_v = PH_GREEN;
					end
				end
				PH_START: begin
					do_copy = 1'b1;
					phase_t_v = PH_CMD;
				end
				PH_GREEN: begin
					color_n[15:8] = expand6(byte_v);
					phase_t_v = PH_BLUE;
				end
				PH_BLUE: begin
					if (!new_q[ENTRY_W]) begin
						q_job.kind = JOB_WRITE;
						q_job.addr_b = {!bank_q, new_q[ENTRY_W-1:0]};
						q_job.data = {color_q[7:0], color_q[15:8], expand6(byte_v)};
					end
					new_n = new_q + 9'd1;
					phase_t_v = PH_CMD;
				end
				default: begin
				end
			endcase

			// copy: skipped on overflow, indices advance either way
			if (do_copy) begin
				if (c_ovf) begin
					q_job.err = ERR_OVERFLOW;
				end else begin
					q_job.kind = JOB_COPY;
					q_job.addr_a = {bank_q, c_start[ENTRY_W-1:0]};
					q_job.addr_b = {!bank_q, new_q[ENTRY_W-1:0]};
					q_job.count = c_count;
					q_job.zero = !oldv_q;
				end
				new_n = c_new_sum[ENTRY_W:0];
				old_n = (c_old_sum > 10'd511) ? 9'h1FF : c_old_sum[ENTRY_W:0];
			end

			// chunk end flags a cut command and commits the new bank unless skipping
			rem_n = rem_dec;
			phase_n = phase_t_v;
			if (rem_dec == 10'd0) begin
				q_job.done = 1'b1;
				if (phase_t_v == PH_START || phase_t_v == PH_GREEN || phase_t_v == PH_BLUE) begin
					q_job.err = ERR_CUT;
				end
				if (phase_t_v != PH_SKIP_ONLY) begin
					bank_n = !bank_q;
					oldv_n = 1'b1;
				end
				phase_n = PH_LENGTH;
			end else if (phase_t_v == PH_CMD && new_n[ENTRY_W]) begin
				phase_n = PH_SKIP_COMMIT;
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LENGTH;
			rem_q <= '0;
			new_q <= '0;
			old_q <= '0;
			pend_q <= '0;
			color_q <= '0;
			bank_q <= 1'b0;
			oldv_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			rem_q <= rem_n;
			new_q <= new_n;
			old_q <= old_n;
			pend_q <= pend_n;
			color_q <= color_n;
			bank_q <= bank_n;
			oldv_q <= oldv_n;
		end
	end

	// enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			en_q <= cfg_data[0];
		end
	end

endmodule

// ----- design/pdd_queue.sv -----
module pdd_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input pdd_pkg::job_t job_in,
	input logic pop,
	output pdd_pkg::job_t job_out,
	output logic full,
	output logic empty
);
	import pdd_pkg::*;

	job_t entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0] count_q;

	assign full = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign job_out = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= job_in;
		end
	end

endmodule

// ----- design/pdd_back.sv -----
module pdd_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input pdd_pkg::job_t q_job,
	output logic q_pop,
	output logic busy,
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata,    // red, green, blue, error_code, zero pad
	output logic m_tlast            // chunk_done
);
	import pdd_pkg::*;

	logic [23:0] mem [2*PALETTE_ENTRIES];
	logic [23:0] rdata_q;

	back_state_t state_q, state_n;
	logic [ENTRY_W:0] src_q, src_n;
	logic [ENTRY_W:0] dst_q, dst_n;
	logic [7:0] left_q, left_n;
	logic zero_q, zero_n;
	logic done_q, done_n;
	logic [1:0] err_q, err_n;

	logic wr_pend_s1;
	logic [ENTRY_W:0] wr_addr_s1;
	logic wr_zero_s1;
	logic copy_rd;

	logic mem_re;
	logic [ENTRY_W:0] mem_raddr;
	logic mem_we;
	logic [ENTRY_W:0] mem_waddr;
	logic [23:0] mem_wdata;

	logic out_load;
	logic [23:0] out_rgb;
	logic out_done;
	logic [1:0] out_err;
	logic out_valid_q;
	logic [23:0] out_rgb_q;
	logic out_done_q;
	logic [1:0] out_err_q;

	assign busy = (state_q != BK_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, out_err_q, out_rgb_q[7:0], out_rgb_q[15:8], out_rgb_q[23:16]};
	assign m_tlast = out_done_q;

	// job sequencer
	always_comb begin
		state_n = state_q;
		src_n = src_q;
		dst_n = dst_q;
		left_n = left_q;
		zero_n = zero_q;
		done_n = done_q;
		err_n = err_q;
		q_pop = 1'b0;
		copy_rd = 1'b0;
		mem_re = 1'b0;
		mem_raddr = src_q;
		mem_we = 1'b0;
		mem_waddr = wr_addr_s1;
		mem_wdata = wr_zero_s1 ? 24'd0 : rdata_q;
		out_load = 1'b0;
		out_rgb = '0;
		out_done = 1'b0;
		out_err = ERR_NONE;

		// delayed write of a copied entry
		if (wr_pend_s1) begin
			mem_we = 1'b1;
		end

		case (state_q)
			BK_IDLE: begin
				if (!q_empty && (!out_valid_q || m_tready)) begin
					q_pop = 1'b1;
					case (q_job.kind)
						JOB_READ: begin
							mem_re = 1'b1;
							mem_raddr = q_job.addr_a;
							state_n = BK_READ;
						end
						JOB_WRITE: begin
							mem_we = 1'b1;
							mem_waddr = q_job.addr_b;
							mem_wdata = q_job.data;
							out_load = 1'b1;
							out_done = q_job.done;
							out_err = q_job.err;
						end
						JOB_COPY: begin
							src_n = q_job.addr_a;
							dst_n = q_job.addr_b;
							left_n = q_job.count;
							zero_n = q_job.zero;
							done_n = q_job.done;
							err_n = q_job.err;
							state_n = BK_COPY;
						end
						default: begin
							out_load = 1'b1;
							out_done = q_job.done;
							out_err = q_job.err;
						end
					endcase
				end
			end
			BK_READ: begin
				out_load = 1'b1;
				out_rgb = rdata_q;
				state_n = BK_IDLE;
			end
			BK_COPY: begin
				mem_re = 1'b1;
				copy_rd = 1'b1;
				src_n = src_q + (ENTRY_W+1)'(1);
				dst_n = dst_q + (ENTRY_W+1)'(1);
				left_n = left_q - 8'd1;
				if (left_q == 8'd1) begin
					state_n = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				out_load = 1'b1;
				out_done = done_q;
				out_err = err_q;
				state_n = BK_IDLE;
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			wr_pend_s1 <= 1'b0;
		end else begin
			state_q <= state_n;
			wr_pend_s1 <= copy_rd;
		end
	end

	// copy bookkeeping, payload only
	always_ff @(posedge clk) begin
		src_q <= src_n;
		dst_q <= dst_n;
		left_q <= left_n;
		zero_q <= zero_n;
		done_q <= done_n;
		err_q <= err_n;
		wr_addr_s1 <= dst_q;
		wr_zero_s1 <= zero_q;
	end

	// palette memory, two banks
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rgb_q <= out_rgb;
			out_done_q <= out_done;
			out_err_q <= out_err;
		end
	end

endmodule

// ----- design/palette_delta_decoder.sv -----
// Palette chunk decoder. Each request on the input stream either feeds one
// chunk byte (tuser = 0) or reads one entry of the committed palette
// (tuser = 1), and every request gives exactly one result, in order. A parser
// takes bytes at one per cycle and hands work to a palette engine through a
// four-deep queue; the engine owns a 2 x 256 x 24 bit memory with one read and
// one write port, one palette entry per cycle. A copy command of up to 128
// entries keeps the engine busy until its last entry has been read, a read
// goes through the registered memory output, and input stalls only when
// the queue is full. palette_enable is sampled at each chunk's length byte.
// Entries never written since reset read back as undefined data.
`include "palette_delta_decoder_defines.svh"

module palette_delta_decoder (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [15:0] s_tdata,     // chunk_byte, entry_index
	input logic [0:0] s_tuser,      // op
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata,    // red, green, blue, error_code, zero pad
	output logic m_tlast,           // chunk_done
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_data      // palette_enable
);
	import pdd_pkg::*;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	logic bk_busy;
	job_t push_job;
	job_t head_job;

	// byte parser
	pdd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.q_full(q_full),
		.q_push(q_push),
		.q_job(push_job)
	);

	// job queue
	pdd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.job_in(push_job),
		.pop(q_pop),
		.job_out(head_job),
		.full(q_full),
		.empty(q_empty)
	);

	// palette engine
	pdd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_job(head_job),
		.q_pop(q_pop),
		.busy(bk_busy),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// queue never written when full or read when empty
	`PDD_ASSERT_IMPLIES(a_push_room, q_push, !q_full)
	`PDD_ASSERT_IMPLIES(a_pop_data, q_pop, !q_empty)
	// engine takes a job only when the result slot frees up
	`PDD_ASSERT_IMPLIES(a_pop_slot, q_pop, !m_tvalid || m_tready)
	// a taken job either shows its result or keeps the engine busy
	`PDD_ASSERT_NEXT(a_pop_progress, q_pop, m_tvalid || bk_busy)

endmodule

// ----- test/palette_check.sv -----
`timescale 1ns / 100ps

// watches the request, result and register channels of the palette decoder,
// predicts each result and compares it with what comes out
module palette_check (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [15:0] s_tdata,     // chunk_byte, entry_index
	input logic [0:0] s_tuser,      // op
	input logic m_tvalid,
	input logic m_tready,
	input logic [31:0] m_tdata,     // red, green, blue, error_code, zero pad
	input logic m_tlast,            // chunk_done
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [0:0] cfg_data,     // palette_enable
	output int mismatches,
	output int outstanding,
	output int requests_seen,
	output int reads_seen,
	output int chunks_closed,
	output int overflows_seen,
	output int cuts_seen
);
	import pdd_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic done;
		logic [1:0] err;
	} decode_result_t;

	// predicted decoder state
	logic [23:0] palette [512];
	logic cur_bank;
	logic have_old;
	logic enable;
	logic [8:0] new_idx;
	logic [8:0] old_idx;
	logic [9:0] bytes_left;
	phase_t stage;
	logic [6:0] pend_count;
	logic [15:0] partial;

	decode_result_t results_q[$];
	int results_checked;

	// 6-bit color value widened to 8 bits
	function automatic logic [7:0] scale_channel(input logic [7:0] v);
		return {v[5:0], v[5:4]};
	endfunction

	// copy a run of old entries into the bank under construction
	function automatic logic [1:0] copy_run(input int count, input int start);
		int t;
		logic [23:0] src;
		logic [1:0] err;
		err = ERR_NONE;
		if (start + count > PALETTE_ENTRIES || int'(new_idx) + count > PALETTE_ENTRIES) begin
			err = ERR_OVERFLOW;
		end else begin
			for (t = 0; t < count; t++) begin
				src = have_old ? palette[{cur_bank, 8'(start + t)}] : 24'h0;
				palette[{~cur_bank, 8'(int'(new_idx) + t)}] = src;
			end
		end
		new_idx = 9'(int'(new_idx) + count);
		old_idx = (start + count > 511) ? 9'd511 : 9'(start + count);
		return err;
	endfunction

	// expected result of one request, advancing the predicted state
	function automatic decode_result_t decode_request(input logic op, input logic [7:0] b,
			input logic [7:0] e);
		decode_result_t r;
		logic [23:0] entry;
		logic [9:0] left_after;
		r = '0;
		if (op) begin
			entry = palette[{cur_bank, e}];
			r.red = entry[23:16];
			r.green = entry[15:8];
			r.blue = entry[7:0];
		end else if (stage == PH_LENGTH || bytes_left == 0) begin
			if (b == 8'h00) begin
				r.done = 1'b1;
				stage = PH_LENGTH;
			end else begin
				bytes_left = {b, 2'b00} - 10'd1;
				new_idx = '0;
				old_idx = '0;
				stage = enable ? PH_CMD : PH_SKIP_ONLY;
			end
		end else begin
			left_after = bytes_left - 10'd1;
			case (stage)
				PH_CMD: begin
					if (b[7]) begin
						r.err = copy_run(int'(b[6:0]) + 1, int'(old_idx));
					end else if (b[6]) begin
						pend_count = {1'b0, b[5:0]} + 7'd1;
						stage = PH_START;
					end else begin
						partial = {8'h00, scale_channel(b)};
						stage = PH_GREEN;
					end
				end
				PH_START: begin
					r.err = copy_run(int'(pend_count), int'(b));
					stage = PH_CMD;
				end
				PH_GREEN: begin
					partial[15:8] = scale_channel(b);
					stage = PH_BLUE;
				end
				PH_BLUE: begin
					if (new_idx < 9'd256)
						palette[{~cur_bank, new_idx[7:0]}] = {partial[7:0], partial[15:8],
							scale_channel(b)};
					new_idx = new_idx + 9'd1;
					stage = PH_CMD;
				end
				default: begin
				end
			endcase
			bytes_left = left_after;
			// chunk end: flag a cut command and commit unless skipping
			if (bytes_left == 0) begin
				r.done = 1'b1;
				if (stage == PH_START || stage == PH_GREEN || stage == PH_BLUE)
					r.err = ERR_CUT;
				if (stage != PH_SKIP_ONLY) begin
					cur_bank = ~cur_bank;
					have_old = 1'b1;
				end
				stage = PH_LENGTH;
			end else if (stage == PH_CMD && new_idx >= 9'd256) begin
				stage = PH_SKIP_COMMIT;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on result %0d: %s is %0h, expected %0h",
			results_checked, what, got, want);
		mismatches++;
	endtask

	// compare results, then predict for the request taken at this edge
	always @(posedge clk or negedge arst_n) begin
		decode_result_t want;
		if (!arst_n) begin
			foreach (palette[i])
				palette[i] = '0;
			cur_bank = 1'b0;
			have_old = 1'b0;
			enable = 1'b0;
			new_idx = '0;
			old_idx = '0;
			bytes_left = '0;
			stage = PH_LENGTH;
			pend_count = '0;
			partial = '0;
			results_q.delete();
			results_checked = 0;
			mismatches = 0;
			outstanding = 0;
			requests_seen = 0;
			reads_seen = 0;
			chunks_closed = 0;
			overflows_seen = 0;
			cuts_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				enable = cfg_data[0];
			if (m_tvalid && m_tready) begin
				if (results_q.size() == 0) begin
					report_mismatch("result with nothing expected", m_tdata, 32'h0);
				end else begin
					want = results_q.pop_front();
					if (m_tdata[7:0] !== want.red)
						report_mismatch("red", 32'(m_tdata[7:0]), 32'(want.red));
					if (m_tdata[15:8] !== want.green)
						report_mismatch("green", 32'(m_tdata[15:8]), 32'(want.green));
					if (m_tdata[23:16] !== want.blue)
						report_mismatch("blue", 32'(m_tdata[23:16]), 32'(want.blue));
					if (m_tdata[25:24] !== want.err)
						report_mismatch("error_code", 32'(m_tdata[25:24]), 32'(want.err));
					if (m_tdata[31:26] !== 6'h00)
						report_mismatch("padding", 32'(m_tdata[31:26]), 32'h0);
					if (m_tlast !== want.done)
						report_mismatch("chunk_done", 32'(m_tlast), 32'(want.done));
				end
				results_checked++;
			end
			if (s_tvalid && s_tready) begin
				want = decode_request(s_tuser[0], s_tdata[7:0], s_tdata[15:8]);
				results_q.push_back(want);
				requests_seen++;
				if (s_tuser[0])
					reads_seen++;
				if (want.done)
					chunks_closed++;
				if (want.err == ERR_OVERFLOW)
					overflows_seen++;
				if (want.err == ERR_CUT)
					cuts_seen++;
			end
			outstanding = results_q.size();
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import pdd_pkg::*;

	localparam int RANDOM_ITEMS = 850;
	localparam int CALM_TAIL = 120;
	localparam int PHASE_ITEMS = 110;
	localparam int DRAIN_CYCLES = 140;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_READ = 1'b1;

	// opening requests as {op, entry_index, chunk_byte}
	localparam logic [16:0] OPENING [25] = '{
		// fill with zeros before any commit, then run past the last entry
		{OP_BYTE, 8'h00, 8'h01}, {OP_BYTE, 8'h00, 8'hFF},
		{OP_BYTE, 8'h00, 8'hFF}, {OP_BYTE, 8'h00, 8'h00},
		// copy the whole committed palette into the other bank
		{OP_BYTE, 8'hFF, 8'h01}, {OP_BYTE, 8'hFF, 8'hFF},
		{OP_BYTE, 8'hFF, 8'hFF}, {OP_BYTE, 8'hFF, 8'hFF},
		// empty chunk
		{OP_BYTE, 8'h00, 8'h00},
		// two raw entries with masked values, a read mid chunk, a cut copy
		{OP_BYTE, 8'h00, 8'h02}, {OP_BYTE, 8'h00, 8'h3F},
		{OP_READ, 8'h80, 8'h00}, {OP_BYTE, 8'h00, 8'hFF},
		{OP_BYTE, 8'h00, 8'h00}, {OP_BYTE, 8'h00, 8'h00},
		{OP_BYTE, 8'h00, 8'h80}, {OP_BYTE, 8'h00, 8'h3F},
		{OP_BYTE, 8'h00, 8'h41},
		// reads of the new entries and the top entry
		{OP_READ, 8'h00, 8'hFF}, {OP_READ, 8'h01, 8'h00},
		{OP_READ, 8'hFF, 8'h00},
		// copies that overflow from a given start and from the running index
		{OP_BYTE, 8'h00, 8'h01}, {OP_BYTE, 8'h00, 8'h7F},
		{OP_BYTE, 8'h00, 8'hFF}, {OP_BYTE, 8'h00, 8'h80}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;      // chunk_byte, entry_index
	logic [0:0] s_tuser = '0;       // op
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;           // red, green, blue, error_code, zero pad
	logic m_tlast;                  // chunk_done
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_data = '0;      // palette_enable

	int mismatches;
	int outstanding;
	int requests_seen;
	int reads_seen;
	int chunks_closed;
	int overflows_seen;
	int cuts_seen;

	bit idle_on = 1'b1;
	int items_sent = 0;
	int sink_hold = 0;
	int cycles = 0;

	palette_delta_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	palette_check checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.requests_seen(requests_seen),
		.reads_seen(reads_seen),
		.chunks_closed(chunks_closed),
		.overflows_seen(overflows_seen),
		.cuts_seen(cuts_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("run stopped at the cycle limit with %0d results pending", outstanding);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side back-pressure in bursts
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			sink_hold <= $urandom_range(0, 5);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// one request, with an occasional gap in front of it
	task automatic send_req(input logic op, input logic [7:0] data, input logic [7:0] idx);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {idx, data};
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	// let every result come back and the palette engine settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(input logic value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// well-formed chunk of random commands, cut where the length ends it,
	// with palette reads mixed in
	task automatic random_chunk();
		logic [7:0] body[$];
		int len;
		int body_len;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			len = 0;
		else if (pick < 85)
			len = $urandom_range(1, 5);
		else if (pick < 97)
			len = $urandom_range(6, 16);
		else
			len = $urandom_range(17, 64);
		body_len = (len > 0) ? 4 * len - 1 : 0;
		while (body.size() < body_len) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				body.push_back(8'($urandom_range(0, 63)));
				body.push_back(8'($urandom));
				body.push_back(8'($urandom));
			end else if (pick < 70) begin
				body.push_back(8'h80 | 8'($urandom_range(0, (pick < 62) ? 15 : 127)));
			end else if (pick < 95) begin
				body.push_back(8'h40 | 8'($urandom_range(0, 63)));
				body.push_back(8'($urandom_range(0, (pick < 88) ? 192 : 255)));
			end else begin
				body.push_back(8'($urandom));
			end
		end
		while (body.size() > body_len) void'(body.pop_back());
		send_req(OP_BYTE, 8'(len), 8'($urandom));
		foreach (body[i]) begin
			if ($urandom_range(0, 9) == 0)
				send_req(OP_READ, 8'($urandom), 8'($urandom));
			send_req(OP_BYTE, body[i], 8'($urandom));
		end
	endtask

	// stimulus
	initial begin
		int phase;
		int phase_start;
		int stop_at;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		write_enable(1'b1);
		foreach (OPENING[i])
			send_req(OPENING[i][16], OPENING[i][7:0], OPENING[i][15:8]);

		// random chunks in phases with different register settings
		stop_at = items_sent + RANDOM_ITEMS;
		phase = 0;
		phase_start = items_sent;
		write_enable(1'b0);
		while (items_sent < stop_at) begin
			if (items_sent - phase_start >= PHASE_ITEMS) begin
				phase++;
				phase_start = items_sent;
				write_enable((phase == 1) ? 1'b1 : logic'($urandom_range(0, 3) != 0));
			end
			idle_on = (items_sent < stop_at - CALM_TAIL) && (phase % 3 != 2);
			random_chunk();
		end

		// drain and verdict
		wait_idle();
		$display("covered %0d requests (%0d palette reads) over %0d register settings",
			requests_seen, reads_seen, phase + 2);
		$display("%0d chunks closed, %0d copy overflows and %0d cut commands reported",
			chunks_closed, overflows_seen, cuts_seen);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
